// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Flag any cycle in which expr holds.
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

// Check that cons holds in every cycle in which ante holds.
`define ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

`endif

// ===== rtl/tpc_pkg.sv =====
// Widths, latencies and constants of the three-point curvature pipeline.
package tpc_pkg;

  localparam int CoordW  = 32;
  localparam int DiffW   = 35;
  localparam int ProdW   = 70;
  localparam int SqW     = 66;
  localparam int LenW    = 67;
  localparam int CMagW   = 66;
  localparam int NumShft = 66;
  localparam int C2W     = 2 * CMagW;
  localparam int Num2W   = C2W + NumShft;
  localparam int AbW     = 2 * LenW;
  localparam int MW      = AbW + LenW;
  localparam int QW      = 64;
  localparam int RootW   = 32;
  localparam int LimbW   = 34;

  localparam int LenLimbs = (LenW + LimbW - 1) / LimbW;
  localparam int AbLimbs  = (AbW + LimbW - 1) / LimbW;
  localparam int CLimbs   = (CMagW + LimbW - 1) / LimbW;

  localparam int AbSteps  = LenLimbs * LenLimbs;
  localparam int MSteps   = AbLimbs * LenLimbs;
  localparam int C2Steps  = CLimbs * CLimbs;
  localparam int C2Delay  = AbSteps + MSteps - C2Steps;
  localparam int DivLat   = QW + 1;
  localparam int SqrtLat  = RootW;
  localparam int Latency  = 5 + AbSteps + MSteps + DivLat + SqrtLat;

  localparam logic signed [DiffW-1:0] NudgeLsb = 35'sd66;

endpackage

// ===== rtl/tpc_delay.sv =====
// Fixed-length register delay line.
module tpc_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [N];

  always_ff @(posedge clk) begin
    sh_r[0] <= d;
    for (int i = 1; i < N; i++) begin
      sh_r[i] <= sh_r[i-1];
    end
  end

  assign q = sh_r[N-1];

endmodule

// ===== rtl/tpc_mul.sv =====
// Pipelined wide unsigned multiplier, one limb partial product per stage.
module tpc_mul #(
  parameter int WA = 64,
  parameter int WB = 64,
  parameter int LW = 34
) (
  input  logic             clk,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int NA    = (WA + LW - 1) / LW;
  localparam int NB    = (WB + LW - 1) / LW;
  localparam int Steps = NA * NB;
  localparam int PW    = WA + WB;
  localparam int EW    = (NA + NB) * LW;

  logic [NA*LW-1:0] a_r   [Steps];
  logic [NB*LW-1:0] b_r   [Steps];
  logic [EW-1:0]    acc_r [Steps];

  for (genvar s = 0; s < Steps; s++) begin : g_step
    localparam int IA = s / NB;
    localparam int IB = s % NB;
    logic [NA*LW-1:0] a_in;
    logic [NB*LW-1:0] b_in;
    logic [EW-1:0]    acc_in;
    logic [2*LW-1:0]  pp;

    if (s == 0) begin : g_first
      assign a_in   = (NA*LW)'(a);
      assign b_in   = (NB*LW)'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_r[s-1];
      assign b_in   = b_r[s-1];
      assign acc_in = acc_r[s-1];
    end

    assign pp = a_in[IA*LW +: LW] * b_in[IB*LW +: LW];

    always_ff @(posedge clk) begin
      a_r[s]   <= a_in;
      b_r[s]   <= b_in;
      acc_r[s] <= acc_in + (EW'(pp) << ((IA + IB) * LW));
    end
  end

  assign p = acc_r[Steps-1][PW-1:0];

endmodule

// ===== rtl/tpc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module tpc_div #(
  parameter int NW = 198,
  parameter int DW = 201,
  parameter int QW = 64
) (
  input  logic          clk,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [QW-1:0] q,
  output logic          ovf
);

  logic [DW-1:0] rem_r [QW+1];
  logic [DW-1:0] d_r   [QW+1];
  logic [QW-1:0] lo_r  [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic          ovf_r [QW+1];
  logic [DW-1:0] rem_init;

  assign rem_init = DW'(n[NW-1:QW]);

  always_ff @(posedge clk) begin
    rem_r[0] <= rem_init;
    d_r[0]   <= d;
    lo_r[0]  <= n[QW-1:0];
    q_r[0]   <= '0;
    ovf_r[0] <= (rem_init >= d);
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    localparam int B = QW - k;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    logic [QW-1:0] q_nxt;

    assign t    = {rem_r[k-1], lo_r[k-1][B]};
    assign ge   = (t >= {1'b0, d_r[k-1]});
    assign diff = t - {1'b0, d_r[k-1]};

    always_comb begin
      q_nxt    = q_r[k-1];
      q_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= ge ? diff[DW-1:0] : t[DW-1:0];
      d_r[k]   <= d_r[k-1];
      lo_r[k]  <= lo_r[k-1];
      q_r[k]   <= q_nxt;
      ovf_r[k] <= ovf_r[k-1];
    end
  end

  assign q   = q_r[QW];
  assign ovf = ovf_r[QW];

endmodule

// ===== rtl/tpc_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
module tpc_sqrt #(
  parameter int RW = 32
) (
  input  logic            clk,
  input  logic [2*RW-1:0] v,
  output logic [RW-1:0]   root
);

  localparam int VW = 2 * RW;

  logic [VW-1:0] v_r    [RW];
  logic [RW-1:0] root_r [RW];
  logic [VW-1:0] sq_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam int B = RW - 1 - k;
    logic [VW-1:0] v_in;
    logic [RW-1:0] root_in;
    logic [VW-1:0] sq_in;
    logic [VW+1:0] tsq;
    logic          take;

    if (k == 0) begin : g_first
      assign v_in    = v;
      assign root_in = '0;
      assign sq_in   = '0;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign root_in = root_r[k-1];
      assign sq_in   = sq_r[k-1];
    end

    assign tsq  = (VW+2)'(sq_in) + ((VW+2)'(root_in) << (B + 1))
                + ((VW+2)'(1) << (2 * B));
    assign take = (tsq <= (VW+2)'(v_in));

    always_ff @(posedge clk) begin
      v_r[k]    <= v_in;
      root_r[k] <= take ? (root_in | (RW'(1) << B)) : root_in;
      sq_r[k]   <= take ? tsq[VW-1:0] : sq_in;
    end
  end

  assign root = root_r[RW-1];

endmodule

// ===== rtl/three_point_curvature_top.sv =====
// Each request passes stages 1 to 4, multipliers, divider, root and output register.
// Throughput: one request per cycle; busy stays low, so start is always taken.
// The rate is set by the fully pipelined multipliers, divider and root stages.
// Reset (rst_n low at a clock edge) clears only the valid pipeline;
// requests in flight are dropped and no strobe follows them.
module three_point_curvature_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tpc_pkg::CoordW-1:0]  in_x_first,
  input  logic signed [tpc_pkg::CoordW-1:0]  in_y_first,
  input  logic signed [tpc_pkg::CoordW-1:0]  in_x_middle,
  input  logic signed [tpc_pkg::CoordW-1:0]  in_y_middle,
  input  logic signed [tpc_pkg::CoordW-1:0]  in_x_last,
  input  logic signed [tpc_pkg::CoordW-1:0]  in_y_last,
  output logic                               out_strobe,
  output logic        [tpc_pkg::RootW-1:0]   out_curvature,
  output logic                               out_straight
);

  localparam int DiffW = tpc_pkg::DiffW;
  localparam int ProdW = tpc_pkg::ProdW;
  localparam int SqW   = tpc_pkg::SqW;
  localparam int LenW  = tpc_pkg::LenW;
  localparam int CMagW = tpc_pkg::CMagW;
  localparam int Lat   = tpc_pkg::Latency;
  localparam int StDly = tpc_pkg::AbSteps + tpc_pkg::MSteps + tpc_pkg::DivLat
                       + tpc_pkg::SqrtLat;

  function automatic logic [SqW-1:0] square(input logic signed [DiffW-1:0] v);
    logic signed [ProdW-1:0] s;
    s = v * v;
    return s[SqW-1:0];
  endfunction

  logic [Lat-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[Lat-2:0], start};
    end
  end

  assign busy = 1'b0;

  // stage 1: differences, with nudge of the first x
  logic signed [DiffW-1:0] x1, y1, x2, y2, x3, y3;
  logic                    x_eq;
  logic signed [DiffW-1:0] dx1_nxt, dx31_nxt;
  logic signed [DiffW-1:0] dx1_r, dy1_r, dx3_r, dy3_r, dx31_r, dy31_r;

  assign x1   = DiffW'(in_x_first);
  assign y1   = DiffW'(in_y_first);
  assign x2   = DiffW'(in_x_middle);
  assign y2   = DiffW'(in_y_middle);
  assign x3   = DiffW'(in_x_last);
  assign y3   = DiffW'(in_y_last);
  assign x_eq = (in_x_first == in_x_middle);

  assign dx1_nxt  = x_eq ? tpc_pkg::NudgeLsb : (x1 - x2);
  assign dx31_nxt = x_eq ? (x3 - x1 - tpc_pkg::NudgeLsb) : (x3 - x1);

  always_ff @(posedge clk) begin
    dx1_r  <= dx1_nxt;
    dy1_r  <= y1 - y2;
    dx3_r  <= x3 - x2;
    dy3_r  <= y3 - y2;
    dx31_r <= dx31_nxt;
    dy31_r <= y3 - y1;
  end

  // stage 2: cross products and squares
  logic signed [ProdW-1:0] p_r, q_r;
  logic [SqW-1:0] sq_dx1_r, sq_dy1_r, sq_dx3_r, sq_dy3_r, sq_dx31_r, sq_dy31_r;

  always_ff @(posedge clk) begin
    p_r       <= dy1_r * dx3_r;
    q_r       <= dy3_r * dx1_r;
    sq_dx1_r  <= square(dx1_r);
    sq_dy1_r  <= square(dy1_r);
    sq_dx3_r  <= square(dx3_r);
    sq_dy3_r  <= square(dy3_r);
    sq_dx31_r <= square(dx31_r);
    sq_dy31_r <= square(dy31_r);
  end

  // stage 3: twice the signed area and squared side lengths
  logic signed [ProdW-1:0] c_r;
  logic [LenW-1:0] len_a_r, len_b_r, len_d_r;

  always_ff @(posedge clk) begin
    c_r     <= p_r - q_r;
    len_a_r <= LenW'(sq_dx1_r) + LenW'(sq_dy1_r);
    len_b_r <= LenW'(sq_dx3_r) + LenW'(sq_dy3_r);
    len_d_r <= LenW'(sq_dx31_r) + LenW'(sq_dy31_r);
  end

  // stage 4: magnitude of the area and collinear flag
  logic [ProdW-1:0] c_neg;
  logic [CMagW-1:0] cmag_nxt, cmag_r;
  logic [LenW-1:0]  len_a4_r, len_b4_r, len_d4_r;
  logic             straight_r;

  assign c_neg    = -c_r;
  assign cmag_nxt = c_r[ProdW-1] ? c_neg[CMagW-1:0] : c_r[CMagW-1:0];

  always_ff @(posedge clk) begin
    cmag_r     <= cmag_nxt;
    straight_r <= (c_r == '0);
    len_a4_r   <= len_a_r;
    len_b4_r   <= len_b_r;
    len_d4_r   <= len_d_r;
  end

  // product of squared lengths, and the squared numerator
  logic [tpc_pkg::AbW-1:0]   ab;
  logic [LenW-1:0]           len_d_al;
  logic [tpc_pkg::MW-1:0]    m;
  logic [tpc_pkg::C2W-1:0]   c2, c2_al;
  logic [tpc_pkg::Num2W-1:0] num2;

  tpc_mul #(.WA(LenW), .WB(LenW), .LW(tpc_pkg::LimbW)) u_mul_ab (
    .clk(clk), .a(len_a4_r), .b(len_b4_r), .p(ab)
  );

  tpc_delay #(.W(LenW), .N(tpc_pkg::AbSteps)) u_dly_d (
    .clk(clk), .d(len_d4_r), .q(len_d_al)
  );

  tpc_mul #(.WA(tpc_pkg::AbW), .WB(LenW), .LW(tpc_pkg::LimbW)) u_mul_m (
    .clk(clk), .a(ab), .b(len_d_al), .p(m)
  );

  tpc_mul #(.WA(CMagW), .WB(CMagW), .LW(tpc_pkg::LimbW)) u_mul_c2 (
    .clk(clk), .a(cmag_r), .b(cmag_r), .p(c2)
  );

  tpc_delay #(.W(tpc_pkg::C2W), .N(tpc_pkg::C2Delay)) u_dly_c2 (
    .clk(clk), .d(c2), .q(c2_al)
  );

  assign num2 = {c2_al, {tpc_pkg::NumShft{1'b0}}};

  // quotient of the squares, then its root
  logic [tpc_pkg::QW-1:0]    quo;
  logic                      ovf, ovf_al, straight_al;
  logic [tpc_pkg::RootW-1:0] root;

  tpc_div #(.NW(tpc_pkg::Num2W), .DW(tpc_pkg::MW), .QW(tpc_pkg::QW)) u_div (
    .clk(clk), .n(num2), .d(m), .q(quo), .ovf(ovf)
  );

  tpc_sqrt #(.RW(tpc_pkg::RootW)) u_sqrt (
    .clk(clk), .v(quo), .root(root)
  );

  tpc_delay #(.W(1), .N(tpc_pkg::SqrtLat)) u_dly_ovf (
    .clk(clk), .d(ovf), .q(ovf_al)
  );

  tpc_delay #(.W(1), .N(StDly)) u_dly_st (
    .clk(clk), .d(straight_r), .q(straight_al)
  );

  // output register
  logic [tpc_pkg::RootW-1:0] curv_nxt, curv_r;
  logic                      out_st_r;

  assign curv_nxt = straight_al ? '0 : (ovf_al ? '1 : root);

  always_ff @(posedge clk) begin
    curv_r   <= curv_nxt;
    out_st_r <= straight_al;
  end

  assign out_strobe    = vld_r[Lat-1];
  assign out_curvature = curv_r;
  assign out_straight  = out_st_r;

endmodule

// ===== rtl/tpc_checker.sv =====
// Port-level checker for the curvature block, bound to its top level.
`include "assert_macros.svh"

module tpc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [tpc_pkg::RootW-1:0]         out_curvature,
  input logic                              out_straight,
  input logic                              out_strobe
);

  `ASSERT_NEVER(a_never_busy, busy)
  `ASSERT_IMPLY(a_straight_zero, out_strobe && out_straight, out_curvature == '0)
  `ASSERT_IMPLY(a_strobe_has_request, out_strobe, $past(start && rst_n, tpc_pkg::Latency))

endmodule

bind three_point_curvature_top tpc_checker u_tpc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .start(start),
  .busy(busy),
  .out_curvature(out_curvature),
  .out_straight(out_straight),
  .out_strobe(out_strobe)
);

// ===== tb/sv/tb_three_point_curvature_top.sv =====
// Testbench for the three-point curvature pipeline: random and directed point triples.
`timescale 1ns / 1ps

module tb_three_point_curvature_top;
  localparam int CoordW = tpc_pkg::CoordW;
  localparam int RootW  = tpc_pkg::RootW;

  class curvature_scoreboard;
    typedef struct {
      bit [RootW-1:0] curvature;
      bit             straight;
    } curvature_t;

    curvature_t expected_q[$];
    int         mismatches;

    static function curvature_t predict_curvature(bit signed [CoordW-1:0] xf,
                                                  bit signed [CoordW-1:0] yf,
                                                  bit signed [CoordW-1:0] xm,
                                                  bit signed [CoordW-1:0] ym,
                                                  bit signed [CoordW-1:0] xl,
                                                  bit signed [CoordW-1:0] yl);
      curvature_t        res;
      longint            x1, y1, x2, y2, x3, y3;
      bit signed [319:0] dx1, dy1, dx3, dy3, dx31, dy31, area;
      bit [319:0]        num, num2, dist_prod, lhs;
      bit [63:0]         sq;
      bit [RootW-1:0]    cand;
      x1 = xf; y1 = yf; x2 = xm; y2 = ym; x3 = xl; y3 = yl;
      if (x1 == x2) x1 += 66;
      dx1 = x1 - x2; dy1 = y1 - y2;
      dx3 = x3 - x2; dy3 = y3 - y2;
      dx31 = x3 - x1; dy31 = y3 - y1;
      area = dy1 * dx3 - dy3 * dx1;
      res.curvature = '0;
      res.straight = 1'b0;
      if (area == 0) begin
        res.straight = 1'b1;
        return res;
      end
      if (area < 0) area = -area;
      num = area <<< 33;
      num2 = num * num;
      dist_prod = (dx1 * dx1 + dy1 * dy1) * (dx3 * dx3 + dy3 * dy3)
                  * (dx31 * dx31 + dy31 * dy31);
      for (int b = RootW - 1; b >= 0; b--) begin
        cand = res.curvature | (32'd1 << b);
        sq = 64'(cand) * 64'(cand);
        lhs = 320'(sq) * dist_prod;
        if (lhs <= num2) res.curvature = cand;
      end
      return res;
    endfunction

    function void note_request(bit signed [CoordW-1:0] xf, bit signed [CoordW-1:0] yf,
                               bit signed [CoordW-1:0] xm, bit signed [CoordW-1:0] ym,
                               bit signed [CoordW-1:0] xl, bit signed [CoordW-1:0] yl);
      expected_q.insert(expected_q.size(), predict_curvature(xf, yf, xm, ym, xl, yl));
    endfunction

    function void check_result(bit [RootW-1:0] curvature, bit straight);
      curvature_t exp_res;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: curvature=%h straight=%b", curvature, straight);
        return;
      end
      exp_res = expected_q.pop_front();
      if (exp_res.curvature !== curvature || exp_res.straight !== straight) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected curvature=%h straight=%b, got curvature=%h straight=%b",
                   exp_res.curvature, exp_res.straight, curvature, straight);
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic signed [CoordW-1:0] in_x_first, in_y_first, in_x_middle;
  logic signed [CoordW-1:0] in_y_middle, in_x_last, in_y_last;
  logic                     out_strobe;
  logic [RootW-1:0]         out_curvature;
  logic                     out_straight;

  curvature_scoreboard sb;
  int                  accepted;
  int                  cycles;
  int                  idle_pct;

  three_point_curvature_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_x_first(in_x_first), .in_y_first(in_y_first),
    .in_x_middle(in_x_middle), .in_y_middle(in_y_middle),
    .in_x_last(in_x_last), .in_y_last(in_y_last),
    .out_strobe(out_strobe), .out_curvature(out_curvature), .out_straight(out_straight)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && start && !busy) begin
      sb.note_request(in_x_first, in_y_first, in_x_middle, in_y_middle, in_x_last, in_y_last);
      accepted <= accepted + 1;
    end
    if (rst_n && out_strobe) sb.check_result(out_curvature, out_straight);
  end

  task automatic send_request(logic signed [CoordW-1:0] xf, logic signed [CoordW-1:0] yf,
                              logic signed [CoordW-1:0] xm, logic signed [CoordW-1:0] ym,
                              logic signed [CoordW-1:0] xl, logic signed [CoordW-1:0] yl);
    int prev;
    prev = accepted;
    start = 1'b1;
    in_x_first = xf; in_y_first = yf;
    in_x_middle = xm; in_y_middle = ym;
    in_x_last = xl; in_y_last = yl;
    do @(negedge clk); while (accepted == prev);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain_requests();
    start = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [CoordW-1:0] random_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed($urandom_range(8192)) - 4096;
      2: return $signed($urandom_range(2000000)) - 1000000;
      default: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(255)
                                        : 32'sh80000000 + $urandom_range(255);
    endcase
  endfunction

  task automatic send_random();
    logic signed [CoordW-1:0] xf, yf, xm, ym, xl, yl;
    int                       k;
    xf = random_coord(); yf = random_coord();
    xm = random_coord(); ym = random_coord();
    xl = random_coord(); yl = random_coord();
    case ($urandom_range(9))
      0: xf = xm;
      1: begin
        k = $urandom_range(4) - 2;
        xm = xf + $signed($urandom_range(2000)) - 1000;
        ym = yf + $signed($urandom_range(2000)) - 1000;
        xl = xm + k * (xm - xf);
        yl = ym + k * (ym - yf);
      end
      2: begin
        xm = xf + $signed($urandom_range(8)) - 4;
        ym = yf + $signed($urandom_range(8)) - 4;
        xl = xm + $signed($urandom_range(8)) - 4;
        yl = ym + $signed($urandom_range(8)) - 4;
      end
      3: begin
        xl = xf; yl = yf;
      end
      default: ;
    endcase
    send_request(xf, yf, xm, ym, xl, yl);
  endtask

  initial begin
    sb = new();
    accepted = 0;
    cycles = 0;
    idle_pct = 35;
    start = 1'b0;
    rst_n = 1'b0;
    {in_x_first, in_y_first, in_x_middle, in_y_middle, in_x_last, in_y_last} = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_request(0, 0, 65536, 0, 65536, 65536);
    send_request(0, 0, 1, 0, 1, 1);
    send_request(0, 0, 0, 0, 0, 0);
    send_request(0, 0, 65536, 65536, 131072, 131072);
    send_request(100, 0, 100, 65536, 0, 131072);
    send_request(32'sh7fffffff, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 0);
    send_request(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                 32'sh7fffffff, 32'sh7fffffff);
    send_request(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                 32'sh80000000, 32'sh80000000);
    send_request(-1, -1, 0, 0, 1, -1);
    send_request(5, 5, 5, 5, 5, 5);
    send_request(5, 5, 5, 5, 7, 9);
    send_request(-65536, 0, 0, 65536, 65536, 0);
    send_request(0, 3, 0, 9, 0, 30);
    send_request(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 0, 0);
    send_request(32'sh80000000, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 0);
    drain_requests();
    repeat (10) @(negedge clk);

    repeat (370) send_random();
    idle_pct = 52;
    repeat (370) send_random();
    drain_requests();
    idle_pct = 0;
    repeat (370) send_random();

    drain_requests();
    repeat (130) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/tpc_pkg.sv
rtl/tpc_delay.sv
rtl/tpc_mul.sv
rtl/tpc_div.sv
rtl/tpc_sqrt.sv
rtl/three_point_curvature_top.sv
rtl/tpc_checker.sv
tb/sv/tb_three_point_curvature_top.sv
